// ----- design/rgb_to_hsv_converter_core_assert.svh -----
// Assertion macros for the RGB to HSV converter core.
// Needs a clock named clk and an active low reset named arst_n in scope.
`ifndef RGB_TO_HSV_CONVERTER_CORE_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define R2H_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define R2H_ASSERT_IMPLY(label, cond, cons, msg) \
	`R2H_ASSERT(label, (cond) |-> (cons), msg)

`endif

// ----- design/r2h_pkg.sv -----
// Shared constants, payload types and stage records of the RGB to HSV converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package r2h_pkg;

	localparam int COMPONENT_BITS = 8;
	localparam int FRACTION_BITS  = 16;
	localparam int SPAN_BITS      = COMPONENT_BITS + 3;
	localparam int NUM_BITS       = COMPONENT_BITS + 4;

	typedef logic [COMPONENT_BITS-1:0] comp_t;
	typedef logic [FRACTION_BITS-1:0]  frac_t;
	typedef logic [SPAN_BITS-1:0]      span_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		comp_t red_level;
		comp_t green_level;
		comp_t blue_level;
	} pix_t;

	typedef struct packed {
		frac_t hue_turn;
		frac_t saturation_frac;
		comp_t value_level;
	} hsv_t;

	typedef struct packed {
		comp_t   red;
		comp_t   green;
		comp_t   blue;
		comp_t   hi;
		comp_t   lo;
		sector_t sector;
	} sort_t;

	typedef struct packed {
		span_t hue_num;
		span_t span;
		comp_t sat_num;
		comp_t hi;
		logic  gray;
		logic  full;
	} setup_t;

	typedef struct packed {
		span_t hue_rem;
		span_t hue_den;
		frac_t hue_q;
		comp_t sat_rem;
		comp_t sat_den;
		frac_t sat_q;
		logic  gray;
		logic  full;
	} div_t;

endpackage

`default_nettype wire

// ----- design/r2h_sort.sv -----
// First pipeline stage: largest and smallest component and the hue sector.
// Depends on r2h_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r2h_sort
	import r2h_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire pix_t  in_data,
	output logic       out_valid,
	input  wire logic  out_ready,
	output sort_t      out_data
);

	logic    vld_s1;
	sort_t   sort_s1;
	comp_t   hi_rg;
	comp_t   lo_rg;
	sort_t   sort_d;

	always_comb begin
		hi_rg = (in_data.red_level >= in_data.green_level) ? in_data.red_level
			: in_data.green_level;
		lo_rg = (in_data.red_level <= in_data.green_level) ? in_data.red_level
			: in_data.green_level;
		sort_d.red   = in_data.red_level;
		sort_d.green = in_data.green_level;
		sort_d.blue  = in_data.blue_level;
		sort_d.hi    = (hi_rg >= in_data.blue_level) ? hi_rg : in_data.blue_level;
		sort_d.lo    = (lo_rg <= in_data.blue_level) ? lo_rg : in_data.blue_level;
		if (in_data.red_level >= in_data.green_level
				&& in_data.red_level >= in_data.blue_level) begin
			sort_d.sector = SEC_RED;
		end else if (in_data.green_level >= in_data.blue_level) begin
			sort_d.sector = SEC_GREEN;
		end else begin
			sort_d.sector = SEC_BLUE;
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sort_s1 <= sort_d;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = sort_s1;

endmodule

`default_nettype wire

// ----- design/r2h_setup.sv -----
// Second pipeline stage: sector numerator, hue span and saturation operands.
// Depends on r2h_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r2h_setup
	import r2h_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire sort_t  in_data,
	output logic        out_valid,
	input  wire logic   out_ready,
	output setup_t      out_data
);

	logic                vld_s2;
	setup_t              setup_s2;
	comp_t               delta;
	logic [NUM_BITS-1:0] d_n;
	logic [NUM_BITS-1:0] r_n;
	logic [NUM_BITS-1:0] g_n;
	logic [NUM_BITS-1:0] b_n;
	logic [NUM_BITS-1:0] num;
	logic [NUM_BITS-1:0] num_w;
	span_t               d_x;
	span_t               span;
	setup_t              setup_d;

	always_comb begin
		delta = in_data.hi - in_data.lo;
		d_n   = {4'b0, delta};
		r_n   = {4'b0, in_data.red};
		g_n   = {4'b0, in_data.green};
		b_n   = {4'b0, in_data.blue};
		d_x   = {3'b0, delta};
		span  = (d_x << 2) + (d_x << 1);
		case (in_data.sector)
			SEC_RED:   num = g_n - b_n;
			SEC_GREEN: num = (d_n << 1) + b_n - r_n;
			SEC_BLUE:  num = (d_n << 2) + r_n - g_n;
			default:   num = '0;
		endcase
		num_w = num[NUM_BITS-1] ? (num + {1'b0, span}) : num;
		setup_d.hue_num = num_w[SPAN_BITS-1:0];
		setup_d.span    = span;
		setup_d.sat_num = delta;
		setup_d.hi      = in_data.hi;
		setup_d.gray    = (delta == '0);
		setup_d.full    = (in_data.lo == '0);
	end

	assign in_ready = !vld_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			setup_s2 <= setup_d;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = setup_s2;

endmodule

`default_nettype wire

// ----- design/r2h_div.sv -----
// Pipelined restoring divider: one hue and one saturation quotient bit per stage.
// Depends on r2h_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r2h_div
	import r2h_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire setup_t  in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output div_t         out_data
);

	div_t                     div_in;
	div_t                     div_s [1:FRACTION_BITS];
	div_t                     nxt   [1:FRACTION_BITS];
	logic [FRACTION_BITS:1]   vld_s;
	logic [FRACTION_BITS+1:1] rdy;

	function automatic div_t div_step(input div_t p);
		div_t                r;
		logic [SPAN_BITS:0]      h_t;
		logic                    h_ge;
		logic [SPAN_BITS:0]      h_r;
		logic [COMPONENT_BITS:0] s_t;
		logic                    s_ge;
		logic [COMPONENT_BITS:0] s_r;
		r    = p;
		h_t  = {p.hue_rem, 1'b0};
		h_ge = (h_t >= {1'b0, p.hue_den});
		h_r  = h_ge ? (h_t - {1'b0, p.hue_den}) : h_t;
		s_t  = {p.sat_rem, 1'b0};
		s_ge = (s_t >= {1'b0, p.sat_den});
		s_r  = s_ge ? (s_t - {1'b0, p.sat_den}) : s_t;
		r.hue_rem = h_r[SPAN_BITS-1:0];
		r.hue_q   = {p.hue_q[FRACTION_BITS-2:0], h_ge};
		r.sat_rem = s_r[COMPONENT_BITS-1:0];
		r.sat_q   = {p.sat_q[FRACTION_BITS-2:0], s_ge};
		return r;
	endfunction

	always_comb begin
		div_in.hue_rem = in_data.hue_num;
		div_in.hue_den = in_data.span;
		div_in.hue_q   = '0;
		div_in.sat_rem = in_data.sat_num;
		div_in.sat_den = in_data.hi;
		div_in.sat_q   = '0;
		div_in.gray    = in_data.gray;
		div_in.full    = in_data.full;
	end

	always_comb begin
		nxt[1] = div_step(div_in);
		for (int k = 2; k <= FRACTION_BITS; k++) begin
			nxt[k] = div_step(div_s[k-1]);
		end
	end

	assign rdy[FRACTION_BITS+1] = out_ready;

	for (genvar k = 1; k <= FRACTION_BITS; k++) begin : g_rdy
		assign rdy[k] = !vld_s[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= FRACTION_BITS; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1] && in_valid) begin
			div_s[1] <= nxt[1];
		end
		for (int k = 2; k <= FRACTION_BITS; k++) begin
			if (rdy[k] && vld_s[k-1]) begin
				div_s[k] <= nxt[k];
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_s[FRACTION_BITS];
	assign out_data  = div_s[FRACTION_BITS];

endmodule

`default_nettype wire

// ----- design/rgb_to_hsv_converter_core.sv -----
// RGB to HSV converter core: sort stage, setup stage, divider and output register.
// Depends on r2h_pkg, r2h_sort, r2h_setup, r2h_div and the assertion macro header.
//
// Usage:
//   pix channel (pix_valid, pix_ready, pix_data) takes one pixel per transfer as
//   red, green and blue levels. hsv channel (hsv_valid, hsv_ready, hsv_data) gives
//   one hue, saturation and value result per pixel, in order.
//   A pix transfer reaches hsv_valid through one sort stage, one setup stage,
//   16 divider stages (one quotient bit each) and the output register.
//   Throughput: one pixel per cycle while hsv_ready is high; the divider sets latency.
//   Each stage holds its item only while the stage after it is full and stalled,
//   so bubbles close up and pix_ready drops only when all 19 stages are full and
//   hsv_ready is low. No transfer is lost or repeated during a stall.
//   Reset clears all stage valid bits; the pipeline starts empty and pix_ready
//   is high right after reset.
//   Gray and black pixels give hue and saturation zero; a pixel with a zero
//   component and some color gives full saturation.
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsv_converter_core_assert.svh"

module rgb_to_hsv_converter_core
	import r2h_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  pix_valid,
	output logic       pix_ready,
	input  wire pix_t  pix_data,
	output logic       hsv_valid,
	input  wire logic  hsv_ready,
	output hsv_t       hsv_data
);

	logic   sort_valid;
	logic   sort_ready;
	sort_t  sort_data;
	logic   setup_valid;
	logic   setup_ready;
	setup_t setup_data;
	logic   div_valid;
	logic   div_ready;
	div_t   div_data;
	logic   hsv_valid_q;
	hsv_t   hsv_q;
	hsv_t   hsv_d;

	r2h_sort u_sort (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_valid),
		.in_ready  (pix_ready),
		.in_data   (pix_data),
		.out_valid (sort_valid),
		.out_ready (sort_ready),
		.out_data  (sort_data)
	);

	r2h_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sort_valid),
		.in_ready  (sort_ready),
		.in_data   (sort_data),
		.out_valid (setup_valid),
		.out_ready (setup_ready),
		.out_data  (setup_data)
	);

	r2h_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (setup_valid),
		.in_ready  (setup_ready),
		.in_data   (setup_data),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	always_comb begin
		hsv_d.value_level = div_data.sat_den;
		if (div_data.gray) begin
			hsv_d.hue_turn        = '0;
			hsv_d.saturation_frac = '0;
		end else begin
			hsv_d.hue_turn        = div_data.hue_q;
			hsv_d.saturation_frac = div_data.full ? '1 : div_data.sat_q;
		end
	end

	assign div_ready = !hsv_valid_q || hsv_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid_q <= 1'b0;
		end else if (div_ready) begin
			hsv_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ready && div_valid) begin
			hsv_q <= hsv_d;
		end
	end

	assign hsv_valid = hsv_valid_q;
	assign hsv_data  = hsv_q;

	`R2H_ASSERT_IMPLY(a_sat_zero_gray, hsv_valid && hsv_data.saturation_frac == '0,
		hsv_data.hue_turn == '0, "zero saturation with nonzero hue")
	`R2H_ASSERT_IMPLY(a_black_zero, hsv_valid && hsv_data.value_level == '0,
		hsv_data.saturation_frac == '0 && hsv_data.hue_turn == '0,
		"black pixel with nonzero hue or saturation")
	`R2H_ASSERT_IMPLY(a_stall_only_full, !pix_ready, hsv_valid && !hsv_ready,
		"input held off without an output stall")

endmodule

`default_nettype wire

// ----- dv/rgb_to_hsv_converter_core_tb.sv -----
// Self-checking testbench for rgb_to_hsv_converter_core: random and corner-case pixels
// go in, every hsv transfer is checked against an in-bench prediction, with random stalls.
// Depends on r2h_pkg and the rgb_to_hsv_converter_core RTL.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_core_tb;
	import r2h_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int DRAIN_CYCLES = 25;
	localparam int IDLE_PCT     = 12;
	localparam int STEADY_FROM  = 300;
	localparam int STEADY_TO    = 550;
	localparam int FRAC_MAX     = (1 << FRACTION_BITS) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	pix_t pix_data = '0;
	logic hsv_valid;
	logic hsv_ready = 1'b0;
	hsv_t hsv_data;

	pix_t pix_pending[$];
	hsv_t hsv_expected[$];

	int cycle_cnt = 0;
	int pix_accepted = 0;
	int gray_cnt = 0;
	int full_sat_cnt = 0;
	int hsv_checked = 0;
	int stall_cnt = 0;
	int mismatch_cnt = 0;
	int unexpected_cnt = 0;

	rgb_to_hsv_converter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv_data  (hsv_data)
	);

	always #5 clk = ~clk;

	function automatic hsv_t hsv_of(pix_t p);
		comp_t   hi;
		comp_t   lo;
		sector_t sec;
		int      delta;
		int      num;
		int      span;
		int      sat;
		hsv_t    res;
		hi = p.red_level;
		if (p.green_level > hi) hi = p.green_level;
		if (p.blue_level > hi) hi = p.blue_level;
		lo = p.red_level;
		if (p.green_level < lo) lo = p.green_level;
		if (p.blue_level < lo) lo = p.blue_level;
		delta = int'(hi) - int'(lo);
		res.value_level = hi;
		res.hue_turn = '0;
		res.saturation_frac = '0;
		if (delta != 0) begin
			sat = (delta << FRACTION_BITS) / int'(hi);
			if (sat > FRAC_MAX) sat = FRAC_MAX;
			res.saturation_frac = frac_t'(sat);
			if (p.red_level == hi) sec = SEC_RED;
			else if (p.green_level == hi) sec = SEC_GREEN;
			else sec = SEC_BLUE;
			case (sec)
				SEC_RED: begin
					num = int'(p.green_level) - int'(p.blue_level);
				end
				SEC_GREEN: begin
					num = 2 * delta + int'(p.blue_level) - int'(p.red_level);
				end
				default: begin
					num = 4 * delta + int'(p.red_level) - int'(p.green_level);
				end
			endcase
			span = 6 * delta;
			if (num < 0) num += span;
			res.hue_turn = frac_t'((num << FRACTION_BITS) / span);
		end
		return res;
	endfunction

	task automatic queue_pixel(int r, int g, int b);
		pix_t p;
		p.red_level = comp_t'(r);
		p.green_level = comp_t'(g);
		p.blue_level = comp_t'(b);
		pix_pending.push_back(p);
	endtask

	function automatic bit steady();
		return cycle_cnt >= STEADY_FROM && cycle_cnt < STEADY_TO;
	endfunction

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				hsv_expected.size());
			$display("rgb_to_hsv_converter_core regression: fail");
			$finish;
		end
	end

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pix_data <= '0;
		end else begin
			if (pix_valid && pix_ready) begin
				hsv_expected.push_back(hsv_of(pix_data));
				pix_accepted++;
				if (hsv_expected[$].saturation_frac == '0) gray_cnt++;
				if (hsv_expected[$].saturation_frac == frac_t'(FRAC_MAX)) full_sat_cnt++;
			end
			// hold payload until the transfer completes
			if (!(pix_valid && !pix_ready)) begin
				if (pix_pending.size() != 0 &&
					(steady() || $urandom_range(99) >= IDLE_PCT)) begin
					pix_valid <= 1'b1;
					pix_data <= pix_pending.pop_front();
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_ready <= 1'b0;
		end else begin
			if (hsv_valid && hsv_ready) begin
				if (hsv_expected.size() == 0) begin
					unexpected_cnt++;
					if (mismatch_cnt + unexpected_cnt <= 10)
						$display("unexpected hsv transfer: hue %0d sat %0d value %0d",
							hsv_data.hue_turn, hsv_data.saturation_frac,
							hsv_data.value_level);
				end else begin
					hsv_checked++;
					if (hsv_data.hue_turn !== hsv_expected[0].hue_turn ||
						hsv_data.saturation_frac !== hsv_expected[0].saturation_frac ||
						hsv_data.value_level !== hsv_expected[0].value_level) begin
						mismatch_cnt++;
						if (mismatch_cnt + unexpected_cnt <= 10)
							$display("mismatch on result %0d: expected hue %0d sat %0d value %0d, got hue %0d sat %0d value %0d",
								hsv_checked, hsv_expected[0].hue_turn,
								hsv_expected[0].saturation_frac,
								hsv_expected[0].value_level, hsv_data.hue_turn,
								hsv_data.saturation_frac, hsv_data.value_level);
					end
					void'(hsv_expected.pop_front());
				end
			end
			if (!hsv_ready) stall_cnt++;
			hsv_ready <= steady() || $urandom_range(99) >= IDLE_PCT;
		end
	end

	initial begin
		int kind;
		int a;
		int b;
		int c;
		int base;

		// black, white, gray and the primaries
		queue_pixel(0, 0, 0);
		queue_pixel(255, 255, 255);
		queue_pixel(128, 128, 128);
		queue_pixel(255, 0, 0);
		queue_pixel(0, 255, 0);
		queue_pixel(0, 0, 255);
		// tied maximum: red beats green and blue, green beats blue
		queue_pixel(255, 255, 0);
		queue_pixel(255, 0, 255);
		queue_pixel(0, 255, 255);
		queue_pixel(200, 200, 100);
		queue_pixel(90, 200, 200);
		// red sector with negative difference wraps around the turn
		queue_pixel(255, 0, 10);
		queue_pixel(255, 254, 255 - 1 - 1);
		queue_pixel(1, 0, 0);
		queue_pixel(0, 0, 1);
		queue_pixel(1, 1, 0);
		queue_pixel(255, 254, 254);
		queue_pixel(254, 255, 255);
		queue_pixel(85, 170, 255);
		queue_pixel(170, 85, 255);
		queue_pixel(255, 170, 85);
		queue_pixel(170, 255, 85);
		queue_pixel(1, 2, 3);
		queue_pixel(254, 253, 255);

		for (int i = 0; i < 730; i++) begin
			kind = $urandom_range(9);
			a = $urandom_range(255);
			b = $urandom_range(255);
			c = $urandom_range(255);
			case (kind)
				5: begin
					queue_pixel(a, a, a);
				end
				6: begin
					case ($urandom_range(2))
						0: queue_pixel(a, a, b);
						1: queue_pixel(a, b, a);
						default: queue_pixel(b, a, a);
					endcase
				end
				7: begin
					case ($urandom_range(2))
						0: queue_pixel(0, b, c);
						1: queue_pixel(a, 0, c);
						default: queue_pixel(a, b, 0);
					endcase
				end
				8: begin
					base = $urandom_range(252);
					queue_pixel(base + $urandom_range(3), base + $urandom_range(3),
						base + $urandom_range(3));
				end
				9: begin
					case ($urandom_range(2))
						0: queue_pixel(255, b, c);
						1: queue_pixel(a, 255, c);
						default: queue_pixel(a, b, 255);
					endcase
				end
				default: begin
					queue_pixel(a, b, c);
				end
			endcase
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pix_pending.size() != 0 || pix_valid) @(posedge clk);
		while (hsv_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d pixels (%0d gray, %0d fully saturated), checked %0d results",
			pix_accepted, gray_cnt, full_sat_cnt, hsv_checked);
		$display("hsv_ready low for %0d cycles, %0d mismatches, %0d unexpected results",
			stall_cnt, mismatch_cnt, unexpected_cnt);
		if (mismatch_cnt == 0 && unexpected_cnt == 0 && hsv_expected.size() == 0) begin
			$display("rgb_to_hsv_converter_core regression: pass");
		end else begin
			$display("rgb_to_hsv_converter_core regression: fail");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/r2h_pkg.sv
design/r2h_sort.sv
design/r2h_setup.sv
design/r2h_div.sv
design/rgb_to_hsv_converter_core.sv
dv/rgb_to_hsv_converter_core_tb.sv
